// File: rtl/core/sorted_key_table_defines.svh
// Assertion macros shared by the sorted key table RTL.
// Depends on nothing; the using module must provide clk and rst_n.
`ifndef SORTED_KEY_TABLE_DEFINES_SVH
`define SORTED_KEY_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_key_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_key_table: next-cycle check failed");

`endif

// File: rtl/core/skt_pkg.sv
// Package for the sorted key table: widths, codes and the cell control and status types.
// Used by skt_cell and sorted_key_table; depends on nothing.
package skt_pkg;

    localparam int KEY_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int CAPACITY_DEF = 16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic                    ins_en;
        logic                    rem_en;
        logic signed [KEY_W-1:0] key;
    } cell_ctl_t;

    // Reported by every cell back to the controller and its neighbors.
    typedef struct packed {
        logic lt;
        logic hit;
    } cell_stat_t;

endpackage

// File: rtl/core/skt_cell.sv
// One slot of the sorted key table: holds one key and shifts with its neighbors.
// Depends on skt_pkg.
module skt_cell
(
    input  logic                            clk,
    input  logic                            occupied,
    input  skt_pkg::cell_ctl_t              ctl,
    input  logic                            left_lt,
    input  logic signed [skt_pkg::KEY_W-1:0] left_key,
    input  logic signed [skt_pkg::KEY_W-1:0] right_key,
    output skt_pkg::cell_stat_t             stat,
    output logic signed [skt_pkg::KEY_W-1:0] key_out
);

    logic signed [skt_pkg::KEY_W-1:0] key_reg;
    logic signed [skt_pkg::KEY_W-1:0] key_next;
    logic                             lt;
    logic                             at_pos;

    // Keys are ascending, so lt forms a run of ones from the left end.
    assign lt       = occupied && (key_reg < ctl.key);
    assign at_pos   = !lt && left_lt;
    assign stat.lt  = lt;
    assign stat.hit = at_pos && occupied && (key_reg == ctl.key);
    assign key_out  = key_reg;

    always_comb
    begin
        key_next = key_reg;
        if (ctl.ins_en && !lt)
        begin
            key_next = at_pos ? ctl.key : left_key;
        end
        else if (ctl.rem_en && !lt)
        begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// File: rtl/core/sorted_key_table.sv
// Sorted key table top level: request handshake, element count and cell row.
// Depends on skt_pkg, skt_cell and sorted_key_table_defines.svh.
//
// The table keeps up to CAPACITY signed 32-bit keys in ascending order, one
// key per cell in a row. A request (req_type, key) is taken when in_valid is
// high and in_stall is low. An insert places the key ahead of the first key
// that is not smaller; a remove deletes one copy of the key. Each request
// yields exactly one result (status, count, empty_res) on the output channel.
// Every cell compares its key with the request key in parallel; the compare
// results pick the insertion point, and each cell then loads its own key, the
// request key, or the key of its left or right neighbor, in a single pass.
// The result is registered and valid in the cycle after the request is taken.
// Throughput is one request per cycle while out_stall holds no result back.
// When the receiver raises out_stall the result holds, and in_stall rises so
// that no further request is taken until the result has been moved on.
// Reset clears the element count and the output valid; the key cells hold
// nothing meaningful until written, and keys beyond the count never affect a result.
// A full table rejects an insert with a full status; a remove of a missing key
// returns a not-found status; neither changes the table.
`include "sorted_key_table_defines.svh"

module sorted_key_table
#(
    parameter int CAPACITY = skt_pkg::CAPACITY_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic signed [skt_pkg::KEY_W-1:0]    key,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [skt_pkg::STATUS_W-1:0]       status,
    output logic [skt_pkg::COUNT_W-1:0]        count,
    output logic                               empty_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic                              in_accept;
    logic                              is_full;
    logic                              found;
    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [skt_pkg::STATUS_W-1:0]      status_reg;
    logic [skt_pkg::STATUS_W-1:0]      status_next;
    logic [skt_pkg::COUNT_W-1:0]       count_out_reg;
    logic                              empty_reg;
    skt_pkg::cell_ctl_t                ctl;
    skt_pkg::cell_stat_t               stat   [CAPACITY];
    logic signed [skt_pkg::KEY_W-1:0]  keys   [CAPACITY];
    logic [CAPACITY-1:0]               hit_vec;

    // A new request may enter whenever the output register is free or is
    // being emptied in this very cycle.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign found     = |hit_vec;

    // The enables go to every cell; a remove only shifts when the key exists.
    assign ctl.key    = key;
    assign ctl.ins_en = in_accept && (req_type == skt_pkg::REQ_INSERT) && !is_full;
    assign ctl.rem_en = in_accept && (req_type == skt_pkg::REQ_REMOVE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic                             occ;
            logic                             l_lt;
            logic signed [skt_pkg::KEY_W-1:0] l_key;
            logic signed [skt_pkg::KEY_W-1:0] r_key;

            assign occ = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_left_end
                // The first cell has no smaller neighbor, so it is a
                // candidate position whenever its own key is not smaller.
                assign l_lt  = 1'b1;
                assign l_key = key;
            end
            else
            begin : g_left_mid
                assign l_lt  = stat[gi-1].lt;
                assign l_key = keys[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_right_end
                // The last slot is beyond the count after any remove.
                assign r_key = keys[gi];
            end
            else
            begin : g_right_mid
                assign r_key = keys[gi+1];
            end

            skt_cell u_cell
            (
                .clk       (clk),
                .occupied  (occ),
                .ctl       (ctl),
                .left_lt   (l_lt),
                .left_key  (l_key),
                .right_key (r_key),
                .stat      (stat[gi]),
                .key_out   (keys[gi])
            );

            assign hit_vec[gi] = stat[gi].hit;
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = skt_pkg::ST_DONE;
        priority if (req_type == skt_pkg::REQ_INSERT && is_full)
        begin
            status_next = skt_pkg::ST_FULL;
        end
        else if (req_type == skt_pkg::REQ_INSERT)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!found)
        begin
            status_next = skt_pkg::ST_MISSING;
        end
        else
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Result payload; it only loads with a request, so a stalled result holds.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg    <= status_next;
            count_out_reg <= skt_pkg::COUNT_W'(count_next);
            empty_reg     <= (count_next == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign count     = count_out_reg;
    assign empty_res = empty_reg;

    `SKT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `SKT_ASSERT_NEXT(a_insert_grows,
        ctl.ins_en, count_reg == $past(count_reg) + CNT_W'(1))
    `SKT_ASSERT_NEXT(a_miss_keeps_count,
        in_accept && req_type == skt_pkg::REQ_REMOVE && !found,
        count_reg == $past(count_reg) && status_reg == skt_pkg::ST_MISSING)
    `SKT_ASSERT_NOW(a_full_status,
        out_valid_reg && status_reg == skt_pkg::ST_FULL, count_reg == CNT_W'(CAPACITY))
    `SKT_ASSERT_NOW(a_one_hit, 1'b1, $onehot0(hit_vec))

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the sorted key table: directed and random insert and remove requests.
// Depends on skt_pkg and sorted_key_table; the expected results come from a
// shadow copy of the table.
module tb_top;

    localparam int CAPACITY   = skt_pkg::CAPACITY_DEF;
    localparam int IDLE_MAX   = 18;
    // Cycles with no handshake on either channel before the run is declared hung.
    // The longest legal quiet stretch is the long receiver hold plus one gap.
    localparam int HANG_LIMIT = 2000;
    localparam int LONG_HOLD  = 80;

    localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [skt_pkg::KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // One result as the block reports it.
    typedef struct packed {
        logic [skt_pkg::STATUS_W-1:0] status;
        logic [skt_pkg::COUNT_W-1:0]  count;
        logic                         empty;
    } table_result_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic                             req_type  = skt_pkg::REQ_INSERT;
    logic signed [skt_pkg::KEY_W-1:0] key       = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [skt_pkg::STATUS_W-1:0]     status;
    logic [skt_pkg::COUNT_W-1:0]      count;
    logic                             empty_res;

    // Shadow copy of the table, kept in ascending signed order.
    logic signed [skt_pkg::KEY_W-1:0] shadow_keys [CAPACITY];
    int                               shadow_count = 0;

    // Results predicted for accepted requests, oldest first.
    table_result_t                    pending_results [$];

    int                               mismatch_count    = 0;
    bit                               send_no_idle      = 1'b0;
    bit                               recv_no_idle      = 1'b0;
    // Set by a test to make the receiver hold off for that many cycles once.
    int                               long_hold_cycles  = 0;

    sorted_key_table u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .count     (count),
        .empty_res (empty_res)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Applies one request to the shadow table and returns the result it must produce.
    // An insert goes ahead of the first key that is not smaller, so equal keys
    // pile up newest first; a remove takes out the first equal key it finds.
    function automatic table_result_t apply_request(logic rtype,
                                                    logic signed [skt_pkg::KEY_W-1:0] k);
        table_result_t res;
        int            pos;
        pos = 0;
        res.status = skt_pkg::ST_DONE;
        while (pos < shadow_count && shadow_keys[pos] < k)
            pos++;
        if (rtype == skt_pkg::REQ_INSERT)
        begin
            if (shadow_count >= CAPACITY)
                res.status = skt_pkg::ST_FULL;
            else
            begin
                for (int i = shadow_count; i > pos; i--)
                    shadow_keys[i] = shadow_keys[i - 1];
                shadow_keys[pos] = k;
                shadow_count++;
            end
        end
        else if (pos >= shadow_count || shadow_keys[pos] != k)
            res.status = skt_pkg::ST_MISSING;
        else
        begin
            for (int i = pos; i + 1 < shadow_count; i++)
                shadow_keys[i] = shadow_keys[i + 1];
            shadow_count--;
        end
        // The count field is only five bits wide, so it wraps for large tables.
        res.count = shadow_count[skt_pkg::COUNT_W-1:0];
        res.empty = (shadow_count == 0);
        return res;
    endfunction

    function automatic int draw_idle(bit no_idle);
        return no_idle ? 0 : $urandom_range(0, IDLE_MAX);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Sends one request. The valid line is only lowered when a gap is drawn, so
    // back-to-back requests keep it high without a low-high pair in one step.
    // The call returns in the time step of the accepting edge.
    task automatic send_request(logic rtype, logic signed [skt_pkg::KEY_W-1:0] k);
        int gap;
        gap = draw_idle(send_no_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rtype;
        key      <= k;
        do @(posedge clk); while (in_stall !== 1'b0);
        pending_results.push_back(apply_request(rtype, k));
    endtask

    // The sender goes quiet until every predicted result has been seen.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Key for a random request: often from a small pool so that removes hit and
    // duplicates form, some extremes, and the rest anywhere in the range.
    function automatic logic signed [skt_pkg::KEY_W-1:0] draw_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return skt_pkg::KEY_W'(int'($urandom_range(0, 15)) - 8);
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // A remove from an empty table must report the key as missing.
    task automatic test_remove_from_empty();
        send_request(skt_pkg::REQ_REMOVE, 32'sd0);
    endtask

    // Both ends of the key range, zero and minus one, a duplicate, a remove of
    // a key that is not stored, and removes that take out the extremes again.
    task automatic test_key_extremes();
        send_request(skt_pkg::REQ_INSERT, KEY_MAX);
        send_request(skt_pkg::REQ_INSERT, KEY_MIN);
        send_request(skt_pkg::REQ_INSERT, 32'sd0);
        send_request(skt_pkg::REQ_INSERT, 32'sd0);
        send_request(skt_pkg::REQ_INSERT, -32'sd1);
        send_request(skt_pkg::REQ_REMOVE, 32'sd7);
        send_request(skt_pkg::REQ_REMOVE, 32'sd0);
        send_request(skt_pkg::REQ_REMOVE, KEY_MAX);
        send_request(skt_pkg::REQ_REMOVE, KEY_MIN);
    endtask

    // Fills the table to capacity, then an insert into the full table is
    // rejected and a remove of a key that is not stored leaves it full.
    task automatic test_full_table();
        int i;
        i = 0;
        while (shadow_count < CAPACITY)
        begin
            send_request(skt_pkg::REQ_INSERT,
                         (i % 4 == 3) ? -32'sd1 : 32'sd1000 - i * 77);
            i++;
        end
        send_request(skt_pkg::REQ_INSERT, 32'sd5);
        send_request(skt_pkg::REQ_REMOVE, 32'sd123456);
    endtask

    // The receiver holds off for a long stretch while requests keep coming
    // without gaps, so the result register fills and the input stalls.
    task automatic test_backpressure();
        send_no_idle     = 1'b1;
        long_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 12; i++)
            send_request((i % 3 == 2) ? skt_pkg::REQ_REMOVE : skt_pkg::REQ_INSERT,
                         draw_key());
        send_no_idle = 1'b0;
    endtask

    // The sender stops until every result has come back, then resumes.
    task automatic test_drain_pause();
        for (int i = 0; i < 4; i++)
            send_request(skt_pkg::REQ_INSERT, draw_key());
        wait_results_drained();
        for (int i = 0; i < 4; i++)
            send_request(skt_pkg::REQ_REMOVE, draw_key());
    endtask

    // Random mix. The table alternates between filling and draining phases so
    // that the count sweeps the whole range, including full and empty tables.
    // Removes mostly name a stored key so that they succeed.
    task automatic test_random_mix(int n_requests);
        bit                               filling;
        logic                             rtype;
        logic signed [skt_pkg::KEY_W-1:0] k;
        filling = (shadow_count < CAPACITY / 2);
        for (int n = 0; n < n_requests; n++)
        begin
            if (n % 40 == 0)
            begin
                send_no_idle = ($urandom_range(0, 3) == 0);
                recv_no_idle = ($urandom_range(0, 3) == 0);
            end
            if (shadow_count == CAPACITY && $urandom_range(0, 2) == 0)
                filling = 1'b0;
            else if (shadow_count == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            if ($urandom_range(0, 99) < (filling ? 80 : 25))
                rtype = skt_pkg::REQ_INSERT;
            else
                rtype = skt_pkg::REQ_REMOVE;
            if (rtype == skt_pkg::REQ_REMOVE && shadow_count > 0 &&
                $urandom_range(0, 9) < 7)
                k = shadow_keys[$urandom_range(0, shadow_count - 1)];
            else
                k = draw_key();
            send_request(rtype, k);
        end
        send_no_idle = 1'b0;
        recv_no_idle = 1'b0;
    endtask

    // Receiver: before each result it draws a number of cycles to hold off.
    // A long hold asked for by a test replaces one draw.
    initial
    begin : result_receiver
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else
                hold = draw_idle(recv_no_idle);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
        end
    end

    // Every result taken at an edge is compared with the oldest prediction.
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", status, 0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (count !== want.count)
                    report_mismatch("count", count, want.count);
                if (empty_res !== want.empty)
                    report_mismatch("empty_res", empty_res, want.empty);
            end
        end
    end

    // Hang detection: too many cycles in a row with no request and no result moving.
    always @(posedge clk)
    begin
        int quiet_cycles;
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_remove_from_empty();
        test_key_extremes();
        test_full_table();
        test_backpressure();
        test_drain_pause();
        test_random_mix(600);

        // Let the last results come back, then allow a few cycles for any
        // stray result that the block should not produce.
        wait_results_drained();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never seen", 0, pending_results.size());

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
